// ===== src/udiv64_pkg.sv =====
// Package for the 64-bit unsigned restoring divider.
// Holds field widths, the controller state type and the controller/datapath
// command and status structs. No dependencies.
package udiv64_pkg;

    localparam int FIELD_W        = 64;
    localparam int DATA_WIDTH_DEF = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } udiv64_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture operands, clear partial remainder
        logic step;     // settle one quotient bit
        logic publish;  // copy result into the output register
    } udiv64_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;     // current step settles the lowest quotient bit
    } udiv64_status_t;

endpackage

// ===== src/unsigned_divide_64_with_remainder.sv =====
// Channel  Dir  Ports                          Payload (lowest bits first)
// s_       in   s_tvalid s_tready s_tdata      dividend_in[63:0], divisor_in[127:64]
// m_       out  m_tvalid m_tready m_tdata      quotient_out[63:0], remainder_out[127:64]
//                        m_tuser               divide_by_zero
//
// After an item is accepted, the divider runs DATA_WIDTH subtract steps through
// the single subtractor, then one publish into the output register. The next item
// is taken only in the idle state after the publish, so items do not overlap.
// The output register holds its result while m_tready is low; a result still
// waiting there stalls the publish and with it the input.
// aresetn is synchronous, active low, and clears the controller only.
module unsigned_divide_64_with_remainder #(
    parameter int DATA_WIDTH = udiv64_pkg::DATA_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [127:0]   s_tdata,   // dividend_in, divisor_in
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata,   // quotient_out, remainder_out
    output logic [0:0]     m_tuser    // divide_by_zero
);
    import udiv64_pkg::*;

    udiv64_cmd_t            cmd;
    udiv64_status_t         status;
    logic [FIELD_W-1:0]     quotient_out;
    logic [FIELD_W-1:0]     remainder_out;
    logic                   divide_by_zero;

    udiv64_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    udiv64_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .status         (status),
        .dividend_in    (s_tdata[FIELD_W-1:0]),
        .divisor_in     (s_tdata[2*FIELD_W-1:FIELD_W]),
        .quotient_out   (quotient_out),
        .remainder_out  (remainder_out),
        .divide_by_zero (divide_by_zero)
    );

    assign m_tdata = {remainder_out, quotient_out};
    assign m_tuser = divide_by_zero;

endmodule

// ===== src/udiv64_dp.sv =====
// Datapath of the restoring divider: operand and partial remainder
// registers, bit counter, subtractor and the output register.
// Depends on udiv64_pkg.
module udiv64_dp #(
    parameter int DATA_WIDTH = udiv64_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  udiv64_pkg::udiv64_cmd_t       cmd,
    output udiv64_pkg::udiv64_status_t    status,
    input  logic [udiv64_pkg::FIELD_W-1:0] dividend_in,
    input  logic [udiv64_pkg::FIELD_W-1:0] divisor_in,
    output logic [udiv64_pkg::FIELD_W-1:0] quotient_out,
    output logic [udiv64_pkg::FIELD_W-1:0] remainder_out,
    output logic                          divide_by_zero
);
    import udiv64_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] part_reg, part_next;
    logic [DATA_WIDTH-1:0] numq_reg, numq_next;   // dividend bits out, quotient bits in
    logic [DATA_WIDTH-1:0] den_reg;
    logic                  dbz_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic [DATA_WIDTH-1:0] out_q_reg;
    logic [DATA_WIDTH-1:0] out_r_reg;
    logic                  out_z_reg;

    logic                  carry;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  take;

    assign carry   = part_reg[DATA_WIDTH-1];
    assign shifted = {part_reg[DATA_WIDTH-2:0], numq_reg[DATA_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {1'b0, den_reg};
    // bit shifted out means the true value already exceeds the divisor
    assign take    = carry | ~diff[DATA_WIDTH];

    always_comb begin
        part_next = part_reg;
        numq_next = numq_reg;
        cnt_next  = cnt_reg;
        if (cmd.load) begin
            part_next = '0;
            numq_next = dividend_in[DATA_WIDTH-1:0];
            cnt_next  = CNT_W'(DATA_WIDTH - 1);
        end else if (cmd.step) begin
            part_next = take ? diff[DATA_WIDTH-1:0] : shifted;
            numq_next = {numq_reg[DATA_WIDTH-2:0], take};
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        part_reg <= part_next;
        numq_reg <= numq_next;
        cnt_reg  <= cnt_next;
        if (cmd.load) begin
            den_reg <= divisor_in[DATA_WIDTH-1:0];
            dbz_reg <= (divisor_in[DATA_WIDTH-1:0] == '0);
        end
        if (cmd.publish) begin
            out_q_reg <= dbz_reg ? '0 : numq_reg;
            out_r_reg <= dbz_reg ? '0 : part_reg;
            out_z_reg <= dbz_reg;
        end
    end

    assign status.last    = (cnt_reg == '0);
    assign quotient_out   = FIELD_W'(out_q_reg);
    assign remainder_out  = FIELD_W'(out_r_reg);
    assign divide_by_zero = out_z_reg;

endmodule

// ===== src/udiv64_ctrl.sv =====
// Controller of the restoring divider: input/output handshake and the
// sequencing of load, step and publish commands. Depends on udiv64_pkg.
module udiv64_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output udiv64_pkg::udiv64_cmd_t    cmd,
    input  udiv64_pkg::udiv64_status_t status
);
    import udiv64_pkg::*;

    udiv64_state_t state_reg, state_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    // output register can take a result this cycle
    assign out_free = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (status.last) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.publish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
